>>> hdl/packbits_run_length_encoder_unit_assert.svh
// Assertion macros used by the run-length encoder datapath.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef PACKBITS_RUN_LENGTH_ENCODER_UNIT_ASSERT_SVH
`define PACKBITS_RUN_LENGTH_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define PBRLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PBRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pbrle_pkg.sv
// Package for the PackBits run-length encoder: item types, controller
// states and the command/status structs between controller and datapath.
`default_nettype none

package pbrle_pkg;

    localparam int MAX_RUN_DEF = 32;
    localparam int BYTE_W      = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              stream_end;
    } t_enc_in;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_header;
        logic              final_of_stream;
        logic              final_of_step;
    } t_enc_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAIN,
        ST_DISPATCH,
        ST_LAST,
        ST_RUN_HDR,
        ST_RUN_VAL,
        ST_LIT_HDR,
        ST_LIT_DATA
    } t_state;

    typedef enum logic [1:0] {
        EMIT_RUN_HDR,
        EMIT_RUN_VAL,
        EMIT_LIT_HDR,
        EMIT_LIT_DATA
    } t_emit_sel;

    typedef struct packed {
        logic      load_in;
        logic      hold_b;
        logic      rep_start;
        logic      rep_inc;
        logic      clear_rep;
        logic      append_held;
        logic      lit_clear;
        logic      rd_rst;
        logic      rd_next;
        logic      emit;
        t_emit_sel emit_sel;
        logic      finish;
        logic      clear_all;
    } t_dp_cmd;

    typedef struct packed {
        logic in_repeat;
        logic rep_match;
        logic rep_next_full;
        logic held_valid;
        logic held_match;
        logic lit_empty;
        logic lit_next_full;
        logic last;
        logic rd_last;
        logic can_emit;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hdl/pbrle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pbrle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/pbrle_ctrl.sv
// Controller state machine of the run-length encoder.
// Depends on pbrle_pkg; drives datapath commands from datapath status.
`default_nettype none

module pbrle_ctrl #(
    parameter int MAX_RUN = pbrle_pkg::MAX_RUN_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire pbrle_pkg::t_dp_stat i_stat,
    output pbrle_pkg::t_dp_cmd       o_cmd
);

    import pbrle_pkg::*;

    localparam logic START_FULL = (MAX_RUN <= 2);

    t_state  r_state, n_state;
    logic    r_run_req, n_run_req;
    logic    r_flush_req, n_flush_req;
    logic    r_tail_done, n_tail_done;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_run_req   <= 1'b0;
            r_flush_req <= 1'b0;
            r_tail_done <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run_req   <= n_run_req;
            r_flush_req <= n_flush_req;
            r_tail_done <= n_tail_done;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_run_req    = r_run_req;
        n_flush_req  = r_flush_req;
        n_tail_done  = r_tail_done;
        cmd          = '0;
        cmd.emit_sel = EMIT_RUN_HDR;
        o_in_ready   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = ST_MAIN;
                end
            end
            ST_MAIN: begin
                n_tail_done = 1'b0;
                n_state     = ST_DISPATCH;
                if (i_stat.in_repeat) begin
                    if (i_stat.rep_match) begin
                        cmd.rep_inc = 1'b1;
                        n_run_req   = i_stat.rep_next_full;
                    end else begin
                        cmd.hold_b = 1'b1;
                        n_run_req  = 1'b1;
                    end
                end else if (!i_stat.held_valid) begin
                    cmd.hold_b = 1'b1;
                end else if (i_stat.held_match) begin
                    cmd.rep_start = 1'b1;
                    n_flush_req   = !i_stat.lit_empty;
                    n_run_req     = START_FULL;
                end else begin
                    cmd.append_held = 1'b1;
                    cmd.hold_b      = 1'b1;
                    n_flush_req     = i_stat.lit_next_full;
                end
            end
            ST_DISPATCH: begin
                if (r_flush_req) begin
                    cmd.rd_rst = 1'b1;
                    n_state    = ST_LIT_HDR;
                end else if (r_run_req) begin
                    n_state = ST_RUN_HDR;
                end else if (i_stat.last && !r_tail_done) begin
                    n_state = ST_LAST;
                end else if (i_stat.can_emit) begin
                    cmd.finish    = 1'b1;
                    cmd.clear_all = i_stat.last;
                    n_state       = ST_IDLE;
                end
            end
            ST_LAST: begin
                n_tail_done = 1'b1;
                n_state     = ST_DISPATCH;
                if (i_stat.in_repeat) begin
                    n_run_req = 1'b1;
                end else begin
                    cmd.append_held = i_stat.held_valid;
                    n_flush_req     = i_stat.held_valid || !i_stat.lit_empty;
                end
            end
            ST_RUN_HDR: begin
                cmd.emit_sel = EMIT_RUN_HDR;
                if (i_stat.can_emit) begin
                    cmd.emit = 1'b1;
                    n_state  = ST_RUN_VAL;
                end
            end
            ST_RUN_VAL: begin
                cmd.emit_sel = EMIT_RUN_VAL;
                if (i_stat.can_emit) begin
                    cmd.emit      = 1'b1;
                    cmd.clear_rep = 1'b1;
                    n_run_req     = 1'b0;
                    n_state       = ST_DISPATCH;
                end
            end
            ST_LIT_HDR: begin
                cmd.emit_sel = EMIT_LIT_HDR;
                if (i_stat.can_emit) begin
                    cmd.emit = 1'b1;
                    n_state  = ST_LIT_DATA;
                end
            end
            ST_LIT_DATA: begin
                cmd.emit_sel = EMIT_LIT_DATA;
                if (i_stat.can_emit) begin
                    cmd.emit    = 1'b1;
                    cmd.rd_next = 1'b1;
                    if (i_stat.rd_last) begin
                        cmd.lit_clear = 1'b1;
                        n_flush_req   = 1'b0;
                        n_state       = ST_DISPATCH;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;

endmodule

`default_nettype wire

>>> hdl/pbrle_dp.sv
// Datapath of the run-length encoder: run and literal state, literal
// buffer RAM, staging and output registers. Depends on pbrle_pkg, pbrle_ram and the assertion header.
`default_nettype none

`include "packbits_run_length_encoder_unit_assert.svh"

module pbrle_dp #(
    parameter int MAX_RUN = pbrle_pkg::MAX_RUN_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pbrle_pkg::t_enc_in  i_in_item,
    input  wire pbrle_pkg::t_dp_cmd  i_cmd,
    output pbrle_pkg::t_dp_stat      o_stat,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output pbrle_pkg::t_enc_out      o_out_item
);

    import pbrle_pkg::*;

    localparam int CNT_W = $clog2(MAX_RUN + 1);
    localparam int IDX_W = $clog2(MAX_RUN);

    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic [BYTE_W-1:0] r_held;
    logic              r_held_valid;
    logic              r_in_repeat;
    logic [CNT_W-1:0]  r_rep_cnt;
    logic [BYTE_W-1:0] r_rep_val;
    logic [CNT_W-1:0]  r_lit_cnt;
    logic [CNT_W-1:0]  r_rd_idx;
    logic [BYTE_W-1:0] r_pend_byte;
    logic              r_pend_hdr;
    logic              r_pend_valid;
    t_enc_out          r_out;
    logic              r_out_valid;

    logic [CNT_W-1:0]  rd_idx_inc;
    logic [IDX_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] ram_rdata;
    logic              out_free;
    logic              push;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_hdr;
    t_enc_out          out_next;

    assign rd_idx_inc = CNT_W'(r_rd_idx + 1'b1);
    assign rd_addr    = i_cmd.rd_next ? rd_idx_inc[IDX_W-1:0] : r_rd_idx[IDX_W-1:0];

    pbrle_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_RUN)
    ) u_lit_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append_held),
        .i_waddr (r_lit_cnt[IDX_W-1:0]),
        .i_wdata (r_held),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || i_out_ready;
    assign push     = (i_cmd.emit || i_cmd.finish) && r_pend_valid;

    always_comb begin
        case (i_cmd.emit_sel)
            EMIT_RUN_HDR: begin
                emit_byte = BYTE_W'(9'd257 - 9'(r_rep_cnt));
                emit_hdr  = 1'b1;
            end
            EMIT_RUN_VAL: begin
                emit_byte = r_rep_val;
                emit_hdr  = 1'b0;
            end
            EMIT_LIT_HDR: begin
                emit_byte = BYTE_W'(r_lit_cnt) - BYTE_W'(1);
                emit_hdr  = 1'b1;
            end
            EMIT_LIT_DATA: begin
                emit_byte = ram_rdata;
                emit_hdr  = 1'b0;
            end
            default: begin
                emit_byte = '0;
                emit_hdr  = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_next.out_byte        = r_pend_byte;
        out_next.is_header       = r_pend_hdr;
        out_next.final_of_stream = i_cmd.finish && r_last;
        out_next.final_of_step   = i_cmd.finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_in_repeat  <= 1'b0;
            r_rep_cnt    <= '0;
            r_lit_cnt    <= '0;
            r_rd_idx     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.hold_b) begin
                r_held_valid <= 1'b1;
            end
            if (i_cmd.rep_start) begin
                r_held_valid <= 1'b0;
                r_in_repeat  <= 1'b1;
                r_rep_cnt    <= CNT_W'(2);
            end
            if (i_cmd.rep_inc) begin
                r_rep_cnt <= CNT_W'(r_rep_cnt + 1'b1);
            end
            if (i_cmd.clear_rep) begin
                r_in_repeat <= 1'b0;
                r_rep_cnt   <= '0;
            end
            if (i_cmd.append_held) begin
                r_lit_cnt <= CNT_W'(r_lit_cnt + 1'b1);
            end
            if (i_cmd.lit_clear) begin
                r_lit_cnt <= '0;
            end
            if (i_cmd.rd_rst) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd_next) begin
                r_rd_idx <= rd_idx_inc;
            end
            if (i_cmd.clear_all) begin
                r_held_valid <= 1'b0;
                r_in_repeat  <= 1'b0;
                r_rep_cnt    <= '0;
                r_lit_cnt    <= '0;
            end
            if (i_cmd.emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_byte <= i_in_item.data_byte;
            r_last <= i_in_item.stream_end;
        end
        if (i_cmd.hold_b) begin
            r_held <= r_byte;
        end
        if (i_cmd.rep_start) begin
            r_rep_val <= r_byte;
        end
        if (i_cmd.emit) begin
            r_pend_byte <= emit_byte;
            r_pend_hdr  <= emit_hdr;
        end
        if (push) begin
            r_out <= out_next;
        end
    end

    always_comb begin
        o_stat.in_repeat     = r_in_repeat;
        o_stat.rep_match     = (r_byte == r_rep_val);
        o_stat.rep_next_full = (r_rep_cnt == CNT_W'(MAX_RUN - 1));
        o_stat.held_valid    = r_held_valid;
        o_stat.held_match    = (r_byte == r_held);
        o_stat.lit_empty     = (r_lit_cnt == '0);
        o_stat.lit_next_full = (r_lit_cnt == CNT_W'(MAX_RUN - 1));
        o_stat.last          = r_last;
        o_stat.rd_last       = (rd_idx_inc == r_lit_cnt);
        o_stat.can_emit      = !r_pend_valid || out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `PBRLE_ASSERT_NOW(a_emit_has_room, i_cmd.emit || i_cmd.finish,
        !r_pend_valid || out_free, "item pushed into a full output stage")
    `PBRLE_ASSERT_NOW(a_append_not_full, i_cmd.append_held,
        r_lit_cnt < CNT_W'(MAX_RUN), "literal append into a full buffer")
    `PBRLE_ASSERT_NOW(a_run_len_range, r_in_repeat,
        r_rep_cnt >= CNT_W'(2) && r_rep_cnt <= CNT_W'(MAX_RUN), "run length out of range")
    `PBRLE_ASSERT_NEXT(a_stream_end_clears, i_cmd.finish && r_last,
        !r_held_valid && !r_in_repeat && r_lit_cnt == '0 && !r_pend_valid,
        "state not cleared after end of stream")

endmodule

`default_nettype wire

>>> hdl/packbits_run_length_encoder_unit.sv
// PackBits run-length encoder, one byte accepted at a time.
// Each item runs through the accept/classify/finish sequence of the controller; a run adds its
// header and value, a literal block of n bytes adds its header and n data bytes, the end-of-stream
// pass adds a tail step, and output stalls hold the sequence. A new item is accepted only when the
// previous one is finished; results leave through a staging register and then an output register.
// Reset: synchronous, active low; clears control state, literal buffer RAM is not cleared.
`default_nettype none

module packbits_run_length_encoder_unit #(
    parameter int MAX_RUN = pbrle_pkg::MAX_RUN_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire pbrle_pkg::t_enc_in i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output pbrle_pkg::t_enc_out     o_out_item
);

    import pbrle_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    pbrle_ctrl #(
        .MAX_RUN (MAX_RUN)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    pbrle_dp #(
        .MAX_RUN (MAX_RUN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
